// File: hw/rtl/mbd_pkg.sv
// Package for the multichannel boxcar decimator.
// Holds payload structs, register indexes, field widths and the controller state type.
// No dependencies.
`default_nettype none

package mbd_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int SUM_BITS         = 32;
  localparam int CH_BITS          = 6;
  localparam int DEF_MAX_CHANNELS = 64;
  localparam int FACTOR_BITS      = 9;
  localparam int CCOUNT_BITS      = 7;
  localparam int BSIZE_BITS       = 13;
  localparam int PHASE_BITS       = 8;
  localparam int BLOCK_BITS       = 12;
  localparam int CFG_IDX_BITS     = 2;
  localparam int CFG_DATA_BITS    = 13;

  localparam logic [CFG_IDX_BITS-1:0] REG_FACTOR   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK    = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CH_BITS-1:0]            channel;
    logic                          restart;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic [CH_BITS-1:0]            out_channel;
    logic                          block_last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_LOAD
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/mbd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module mbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mbd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mbd_pkg for operand widths.
`default_nettype none

module mbd_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [mbd_pkg::SUM_BITS-1:0]     dividend,
  input  wire logic [mbd_pkg::FACTOR_BITS-1:0]  divisor,
  output logic                                  done,
  output logic      [mbd_pkg::SUM_BITS-1:0]     quotient
);

  localparam int CW = $clog2(mbd_pkg::SUM_BITS);
  localparam logic [CW-1:0] LAST = CW'(mbd_pkg::SUM_BITS - 1);

  logic                              busy_r;
  logic [CW-1:0]                     cnt_r;
  logic [mbd_pkg::FACTOR_BITS-1:0]   rem_r;
  logic [mbd_pkg::FACTOR_BITS-1:0]   dsr_r;
  logic [mbd_pkg::SUM_BITS-1:0]      quo_r;
  logic [mbd_pkg::FACTOR_BITS:0]     rem_s;
  logic                              ge;
  logic [mbd_pkg::FACTOR_BITS:0]     rem_sub;

  always_comb begin
    rem_s   = {rem_r, quo_r[mbd_pkg::SUM_BITS-1]};
    ge      = rem_s >= {1'b0, dsr_r};
    rem_sub = rem_s - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dsr_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[mbd_pkg::FACTOR_BITS-1:0] : rem_s[mbd_pkg::FACTOR_BITS-1:0];
      quo_r <= {quo_r[mbd_pkg::SUM_BITS-2:0], ge};
    end
  end

  assign done     = busy_r && (cnt_r == LAST);
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: hw/rtl/multichannel_boxcar_decimator_unit.sv
// Multichannel boxcar decimator: per-channel sums in a RAM, read-modify-write per transaction.
// Depends on mbd_pkg, mbd_ram and mbd_div.
// An accumulate-only sample goes IDLE, CALC, IDLE; a group-end sample also runs the
// 32-step serial divider in DIV, then waits in LOAD until the output register is free.
// Only IDLE takes samples; out-of-range ones are dropped. Reset (sync, active low) sets
// registers to 2, 1, 1, counters to 0, clears every valid bit: all sums then read as zero.
`default_nettype none

module multichannel_boxcar_decimator_unit #(
  parameter int MAX_CHANNELS = mbd_pkg::DEF_MAX_CHANNELS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire mbd_pkg::in_t                        in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output mbd_pkg::out_t                            out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mbd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [mbd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int CH_LIMIT = 2 ** mbd_pkg::CH_BITS;
  localparam int DEPTH    = (MAX_CHANNELS < CH_LIMIT) ? MAX_CHANNELS : CH_LIMIT;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [mbd_pkg::CCOUNT_BITS-1:0] DEPTH_C = mbd_pkg::CCOUNT_BITS'(DEPTH);
  localparam logic [mbd_pkg::SUM_BITS-1:0] SUM_MAX = {1'b0, {(mbd_pkg::SUM_BITS-1){1'b1}}};
  localparam logic [mbd_pkg::SUM_BITS-1:0] SUM_MIN = {1'b1, {(mbd_pkg::SUM_BITS-1){1'b0}}};
  localparam logic [mbd_pkg::SUM_BITS-1:0] AVG_HI =
    mbd_pkg::SUM_BITS'((64'd1 << (mbd_pkg::SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [mbd_pkg::SUM_BITS-1:0] AVG_LO_MAG =
    mbd_pkg::SUM_BITS'(64'd1 << (mbd_pkg::SAMPLE_BITS - 1));

  mbd_pkg::state_t state_r, state_nxt;

  logic [mbd_pkg::FACTOR_BITS-1:0] factor_r;
  logic [mbd_pkg::CCOUNT_BITS-1:0] chans_r;
  logic [mbd_pkg::BSIZE_BITS-1:0]  bsize_r;
  logic [mbd_pkg::FACTOR_BITS-1:0] factor_eff;
  logic [mbd_pkg::CCOUNT_BITS-1:0] chans_eff;
  logic [mbd_pkg::BSIZE_BITS-1:0]  bsize_eff;

  logic [mbd_pkg::PHASE_BITS-1:0]  phase_r;
  logic [mbd_pkg::BLOCK_BITS-1:0]  block_r;
  logic [DEPTH-1:0]                vld_r;
  mbd_pkg::in_t                    in_r;
  logic                            neg_r;
  logic                            blast_r;
  logic                            out_valid_r;
  mbd_pkg::out_t                   out_r;

  logic                            in_fire;
  logic                            in_range;
  logic [AW-1:0]                   addr;
  logic [mbd_pkg::SUM_BITS-1:0]    ram_rdata;
  logic [mbd_pkg::SUM_BITS-1:0]    sum_rd;
  logic [mbd_pkg::SUM_BITS:0]      acc_wide;
  logic [mbd_pkg::SUM_BITS-1:0]    acc;
  logic [mbd_pkg::SUM_BITS-1:0]    acc_mag;
  logic                            last_inst;
  logic                            last_ch;
  logic                            blk_end;
  logic                            ram_re;
  logic                            ram_we;
  logic [mbd_pkg::SUM_BITS-1:0]    ram_wdata;
  logic                            div_start;
  logic                            div_done;
  logic [mbd_pkg::SUM_BITS-1:0]    div_quo;
  logic                            out_free;
  logic                            out_load;
  logic [mbd_pkg::SAMPLE_BITS-1:0] avg;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= mbd_pkg::FACTOR_BITS'(2);
      chans_r  <= mbd_pkg::CCOUNT_BITS'(1);
      bsize_r  <= mbd_pkg::BSIZE_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbd_pkg::REG_FACTOR:   factor_r <= cfg_data[mbd_pkg::FACTOR_BITS-1:0];
        mbd_pkg::REG_CHANNELS: chans_r  <= cfg_data[mbd_pkg::CCOUNT_BITS-1:0];
        mbd_pkg::REG_BLOCK:    bsize_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (factor_r < mbd_pkg::FACTOR_BITS'(2)) begin
      factor_eff = mbd_pkg::FACTOR_BITS'(2);
    end else if (factor_r > mbd_pkg::FACTOR_BITS'(256)) begin
      factor_eff = mbd_pkg::FACTOR_BITS'(256);
    end else begin
      factor_eff = factor_r;
    end
    if (chans_r == '0) begin
      chans_eff = mbd_pkg::CCOUNT_BITS'(1);
    end else if (chans_r > DEPTH_C) begin
      chans_eff = DEPTH_C;
    end else begin
      chans_eff = chans_r;
    end
    if (bsize_r == '0) begin
      bsize_eff = mbd_pkg::BSIZE_BITS'(1);
    end else if (bsize_r > mbd_pkg::BSIZE_BITS'(4096)) begin
      bsize_eff = mbd_pkg::BSIZE_BITS'(4096);
    end else begin
      bsize_eff = bsize_r;
    end
  end

  // input side
  assign in_ready = (state_r == mbd_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_range = {1'b0, in_data.channel} < chans_eff;
  assign addr     = in_r.channel[AW-1:0];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
  end

  // read-modify-write datapath
  always_comb begin
    sum_rd   = vld_r[addr] ? ram_rdata : '0;
    acc_wide = {sum_rd[mbd_pkg::SUM_BITS-1], sum_rd}
             + (mbd_pkg::SUM_BITS+1)'(in_r.sample);
    if (acc_wide[mbd_pkg::SUM_BITS] != acc_wide[mbd_pkg::SUM_BITS-1]) begin
      acc = acc_wide[mbd_pkg::SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      acc = acc_wide[mbd_pkg::SUM_BITS-1:0];
    end
    acc_mag   = acc[mbd_pkg::SUM_BITS-1] ? (~acc + 1'b1) : acc;
    last_inst = {1'b0, phase_r} >= (factor_eff - 1'b1);
    last_ch   = {1'b0, in_r.channel} == (chans_eff - 1'b1);
    blk_end   = {1'b0, block_r} >= (bsize_eff - 1'b1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbd_pkg::ST_IDLE: if (in_fire && in_range) state_nxt = mbd_pkg::ST_CALC;
      mbd_pkg::ST_CALC: state_nxt = last_inst ? mbd_pkg::ST_DIV : mbd_pkg::ST_IDLE;
      mbd_pkg::ST_DIV:  if (div_done) state_nxt = mbd_pkg::ST_LOAD;
      mbd_pkg::ST_LOAD: if (out_free) state_nxt = mbd_pkg::ST_IDLE;
      default:          state_nxt = mbd_pkg::ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    ram_wdata = last_inst ? '0 : acc;
    case (state_r)
      mbd_pkg::ST_IDLE: ram_re = in_fire && in_range;
      mbd_pkg::ST_CALC: begin
        ram_we    = 1'b1;
        div_start = last_inst;
      end
      mbd_pkg::ST_DIV:  ;
      mbd_pkg::ST_LOAD: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // run state: valid bits and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      phase_r <= '0;
      block_r <= '0;
    end else if (in_fire && in_data.restart) begin
      vld_r   <= '0;
      phase_r <= '0;
      block_r <= '0;
    end else if (ram_we) begin
      vld_r[addr] <= 1'b1;
      if (last_ch) begin
        if (last_inst) begin
          phase_r <= '0;
          block_r <= blk_end ? '0 : block_r + 1'b1;
        end else begin
          phase_r <= phase_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_r   <= acc[mbd_pkg::SUM_BITS-1];
      blast_r <= last_ch && blk_end;
    end
  end

  mbd_ram #(
    .WIDTH (mbd_pkg::SUM_BITS),
    .DEPTH (DEPTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_data.channel[AW-1:0]),
    .rdata (ram_rdata)
  );

  mbd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_mag),
    .divisor  (factor_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  // output register
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    if (neg_r) begin
      avg = (div_quo > AVG_LO_MAG) ? AVG_LO_MAG[mbd_pkg::SAMPLE_BITS-1:0]
                                   : (~div_quo[mbd_pkg::SAMPLE_BITS-1:0] + 1'b1);
    end else begin
      avg = (div_quo > AVG_HI) ? AVG_HI[mbd_pkg::SAMPLE_BITS-1:0]
                               : div_quo[mbd_pkg::SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.average     <= avg;
      out_r.out_channel <= in_r.channel;
      out_r.block_last  <= blast_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == mbd_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_range) |=> state_r == mbd_pkg::ST_CALC)
    else $error("in-range transaction did not start a read-modify-write");

  a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.restart) |=> (vld_r == '0 && phase_r == '0 && block_r == '0))
    else $error("restart left run state behind");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result load lost");
`endif

endmodule

`default_nettype wire

// File: verif/mbd_average_checker.sv
// Checker for the multichannel boxcar decimator: tracks sums, phase and block position per transaction.
// Watches the sample, result and register-write channels and compares every average in order.
// Depends on mbd_pkg.
module mbd_average_checker
  import mbd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  in_t                      in_data,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  out_t                     out_data,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       errors,
  output int                       pending,
  output int                       checked
);

  localparam longint SUM_HI = (longint'(1) <<< (SUM_BITS - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint AVG_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint AVG_LO = -AVG_HI - 1;

  logic [FACTOR_BITS-1:0]     factor_reg;
  logic [CCOUNT_BITS-1:0]     chans_reg;
  logic [BSIZE_BITS-1:0]      block_reg;
  logic signed [SUM_BITS-1:0] chan_sums [DEF_MAX_CHANNELS];
  logic [PHASE_BITS-1:0]      phase;
  logic [BLOCK_BITS-1:0]      block_pos;
  out_t                       expected_averages [$];
  int                         err_cnt = 0;
  int                         seen = 0;
  int                         queued = 0;

  assign errors  = err_cnt;
  assign pending = queued;
  assign checked = seen;

  function automatic int eff_factor();
    if (factor_reg < 2) return 2;
    if (factor_reg > 256) return 256;
    return int'(factor_reg);
  endfunction

  function automatic int eff_chans();
    if (chans_reg < 1) return 1;
    if (chans_reg > DEF_MAX_CHANNELS) return DEF_MAX_CHANNELS;
    return int'(chans_reg);
  endfunction

  function automatic int eff_block();
    if (block_reg < 1) return 1;
    if (block_reg > 4096) return 4096;
    return int'(block_reg);
  endfunction

  task automatic clear_run();
    foreach (chan_sums[i]) chan_sums[i] = '0;
    phase     = '0;
    block_pos = '0;
  endtask

  task automatic accumulate_sample(input in_t s);
    longint acc;
    longint avg;
    int     f;
    int     c;
    int     b;
    int     ch;
    bit     closes;
    out_t   r;
    f = eff_factor();
    c = eff_chans();
    b = eff_block();
    if (s.restart) clear_run();
    ch = int'(s.channel);
    if (ch >= c) return;
    acc = longint'(chan_sums[ch]) + longint'($signed(s.sample));
    if (acc > SUM_HI) acc = SUM_HI;
    if (acc < SUM_LO) acc = SUM_LO;
    closes = (int'(phase) >= f - 1);
    if (closes) begin
      avg = acc / longint'(f);
      if (avg > AVG_HI) avg = AVG_HI;
      if (avg < AVG_LO) avg = AVG_LO;
      r.average     = avg[SAMPLE_BITS-1:0];
      r.out_channel = ch[CH_BITS-1:0];
      r.block_last  = (ch == c - 1) && (int'(block_pos) >= b - 1);
      expected_averages.push_back(r);
      chan_sums[ch] = '0;
    end else begin
      chan_sums[ch] = acc[SUM_BITS-1:0];
    end
    if (ch == c - 1) begin
      if (closes) begin
        phase = '0;
        if (int'(block_pos) >= b - 1) block_pos = '0;
        else block_pos = block_pos + 1'b1;
      end else begin
        phase = phase + 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      factor_reg = FACTOR_BITS'(2);
      chans_reg  = CCOUNT_BITS'(1);
      block_reg  = BSIZE_BITS'(1);
      clear_run();
      expected_averages.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FACTOR:   factor_reg = cfg_data[FACTOR_BITS-1:0];
          REG_CHANNELS: chans_reg  = cfg_data[CCOUNT_BITS-1:0];
          REG_BLOCK:    block_reg  = cfg_data[BSIZE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) accumulate_sample(in_data);
      if (out_valid && out_ready) begin
        if (expected_averages.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result avg=%0d ch=%0d last=%0b", $time,
                   out_data.average, out_data.out_channel, out_data.block_last);
        end else begin
          want = expected_averages.pop_front();
          seen++;
          if (out_data.average !== want.average ||
              out_data.out_channel !== want.out_channel ||
              out_data.block_last !== want.block_last) begin
            err_cnt++;
            $display("%0t: mismatch, expected avg=%0d ch=%0d last=%0b, got avg=%0d ch=%0d last=%0b",
                     $time, want.average, want.out_channel, want.block_last,
                     out_data.average, out_data.out_channel, out_data.block_last);
          end
        end
      end
    end
    queued = expected_averages.size();
  end

endmodule

// File: verif/tb.sv
// Testbench top for multichannel_boxcar_decimator_unit: clock, reset, register setup and samples.
// Depends on mbd_pkg and mbd_average_checker, which predicts and checks every average.
module tb;
  import mbd_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 700;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  in_t                      in_data   = '0;
  logic                     in_ready;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_t                     out_data;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                     cfg_ready;

  int errors;
  int pending;
  int checked;
  int send_idle_pct = 26;
  int recv_idle_pct = 72;
  int sent          = 0;
  int writes        = 0;
  int cycle_cnt     = 0;
  int stall_left    = 0;
  bit stall_kick    = 1'b0;
  bit kick_seen     = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  multichannel_boxcar_decimator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mbd_average_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random back-pressure plus a long hold-off when kicked
  always @(negedge clk) begin
    if (stall_kick != kick_seen) begin
      kick_seen  = stall_kick;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_t mk(input int ch, input int value, input bit clr);
    in_t d;
    d.sample  = value[SAMPLE_BITS-1:0];
    d.channel = ch[CH_BITS-1:0];
    d.restart = clr;
    return d;
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return int'($urandom_range(32)) - 16;
      default: return int'($urandom);
    endcase
  endfunction

  task automatic push_sample(input in_t d);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    writes++;
  endtask

  // wait until every average is out and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int snd, input int rcv);
    @(posedge clk);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  // mostly complete instants, with ignored channels, skips, repeats and restarts mixed in
  task automatic stream(input int chans, input int budget);
    int taken;
    taken = 0;
    while (taken < budget) begin
      for (int ch = 0; ch < chans && taken < budget; ch++) begin
        if (chans < DEF_MAX_CHANNELS && $urandom_range(99) < 4)
          push_sample(mk($urandom_range(DEF_MAX_CHANNELS - 1, chans), pick_sample(),
                         $urandom_range(9) == 0));
        if ($urandom_range(99) < 2) continue;
        push_sample(mk(ch, pick_sample(), $urandom_range(199) == 0));
        taken++;
        if ($urandom_range(99) == 0) begin
          push_sample(mk(ch, pick_sample(), 1'b0));
          taken++;
        end
      end
    end
  endtask

  task automatic run_setting(input int f, input int c, input int b, input int chans,
                             input int budget);
    settle();
    write_reg(REG_FACTOR, f);
    write_reg(REG_CHANNELS, c);
    write_reg(REG_BLOCK, b);
    stream(chans, budget);
  endtask

  // drive channel 0 past the sum limit without closing an instant
  task automatic pile_up(input int value);
    settle();
    write_reg(REG_FACTOR, 2);
    write_reg(REG_CHANNELS, 2);
    write_reg(REG_BLOCK, 1);
    push_sample(mk(0, value, 1'b1));
    repeat (269) push_sample(mk(0, value, 1'b0));
    push_sample(mk(1, 0, 1'b0));
    push_sample(mk(0, value, 1'b0));
    push_sample(mk(1, 0, 1'b0));
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: factor 2, one channel, block of one
    push_sample(mk(0, SAMPLE_MAX, 1'b0));
    push_sample(mk(0, SAMPLE_MAX, 1'b0));
    push_sample(mk(0, SAMPLE_MIN, 1'b0));
    push_sample(mk(0, SAMPLE_MIN, 1'b0));
    push_sample(mk(0, 3, 1'b0));
    push_sample(mk(0, -4, 1'b0));
    push_sample(mk(0, -3, 1'b0));
    push_sample(mk(0, 0, 1'b0));
    push_sample(mk(5, 123, 1'b0));
    push_sample(mk(0, 100, 1'b0));
    push_sample(mk(0, 7, 1'b1));
    push_sample(mk(0, 1, 1'b0));
    push_sample(mk(63, -1, 1'b1));
    settle();
    write_reg(REG_FACTOR, 3);
    write_reg(REG_CHANNELS, 2);
    write_reg(REG_BLOCK, 2);
    write_reg(REG_SPARE, $urandom_range(8191));
    push_sample(mk(1, 5, 1'b0));
    push_sample(mk(0, 9, 1'b0));
    push_sample(mk(1, 6, 1'b0));
    push_sample(mk(0, -1, 1'b0));
    push_sample(mk(1, 1, 1'b0));

    run_setting(2, 1, 1, 1, 80);
    run_setting(3, 4, 3, 4, 120);
    run_setting(0, 0, 0, 1, 50);
    run_setting(2, 64, 1, 64, 160);

    settle();
    set_idling(72, 26);
    run_setting(256, 1, 8191, 1, 280);
    run_setting(1, 5, 4, 5, 90);
    run_setting(7, 2, 5000, 2, 80);
    run_setting(2, 100, 2, 64, 80);

    settle();
    set_idling(0, 0);
    run_setting(6, 3, 7, 3, 120);
    run_setting(2, 1, 3, 1, 0);
    @(posedge clk);
    stall_kick = ~stall_kick;
    stream(1, 100);
    run_setting(2, 1, 4096, 1, 50);
    pile_up(SAMPLE_MAX);
    pile_up(SAMPLE_MIN);

    settle();
    $display("Sent %0d samples and %0d register writes; %0d averages compared.",
             sent, writes, checked);
    $display("Traffic mixed idle ratios, a long output hold-off, restarts, %s",
             "ignored channels, saturation and mid-group register changes.");
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
